/* hdl/assert_macros.svh */
// Assertion helpers for the top-level RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PCV_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define PCV_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* hdl/pcv_pkg.sv */
package pcv_pkg;

  // Deepest row the line store holds.
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 10;

  localparam int PIX_W     = 8;
  localparam int YUV_W     = 3 * PIX_W;
  localparam int MODE_W    = 4;
  localparam int SIZE_W    = 11;
  localparam int THRESH_W  = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;
  localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;

  localparam logic [SIZE_W-1:0]   WIDTH_RST  = 11'd640;
  localparam logic [SIZE_W-1:0]   HEIGHT_RST = 11'd480;
  localparam logic [THRESH_W-1:0] THRESH_RST = 8'd10;

  typedef enum logic [MODE_W-1:0] {
    MODE_RGB   = 4'd0,
    MODE_Y     = 4'd1,
    MODE_U     = 4'd2,
    MODE_V     = 4'd3,
    MODE_RED   = 4'd4,
    MODE_GREEN = 4'd5,
    MODE_BLUE  = 4'd6,
    MODE_HUE   = 4'd7,
    MODE_SAT   = 4'd8,
    MODE_VAL   = 4'd9,
    MODE_EDGE  = 4'd10
  } pcv_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISPLAY_MODE   = 2'd0,
    REG_IMAGE_WIDTH    = 2'd1,
    REG_IMAGE_HEIGHT   = 2'd2,
    REG_EDGE_THRESHOLD = 2'd3
  } pcv_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] y;
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] v;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] sat;
    logic [PIX_W-1:0] val;
  } pcv_pixel_t;

  // Everything the shading logic needs about one item, captured at accept.
  typedef struct packed {
    pcv_pixel_t       pix;
    logic [YUV_W-1:0] left_yuv;
    logic             edge_ok;
    logic             frame_end;
  } pcv_stage_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pcv_color_t;

endpackage

/* hdl/pcv_if.sv */
interface pcv_pixel_if
  import pcv_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_y;
  logic [PIX_W-1:0] pixel_u;
  logic [PIX_W-1:0] pixel_v;
  logic [PIX_W-1:0] pixel_red;
  logic [PIX_W-1:0] pixel_green;
  logic [PIX_W-1:0] pixel_blue;
  logic [PIX_W-1:0] pixel_hue;
  logic [PIX_W-1:0] pixel_saturation;
  logic [PIX_W-1:0] pixel_value;

  modport source (
    output valid, pixel_y, pixel_u, pixel_v, pixel_red, pixel_green, pixel_blue,
           pixel_hue, pixel_saturation, pixel_value,
    input  ready
  );
  modport sink (
    input  valid, pixel_y, pixel_u, pixel_v, pixel_red, pixel_green, pixel_blue,
           pixel_hue, pixel_saturation, pixel_value,
    output ready
  );
endinterface

interface pcv_display_if
  import pcv_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;
  logic             frame_end;

  modport source (
    output valid, out_red, out_green, out_blue, frame_end,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, frame_end,
    output ready
  );
endinterface

/* hdl/pcv_ram.sv */
module pcv_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when both ports hit the same address.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/pcv_shade.sv */
module pcv_shade
  import pcv_pkg::*;
(
  input  pcv_stage_t          stage,
  input  logic [YUV_W-1:0]    up_yuv,
  input  logic [MODE_W-1:0]   display_mode,
  input  logic [THRESH_W-1:0] edge_threshold,
  output pcv_color_t          color
);

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [PIX_W-1:0] max_diff(input logic [PIX_W-1:0] c,
                                                input logic [PIX_W-1:0] l,
                                                input logic [PIX_W-1:0] u);
    logic [PIX_W-1:0] dl;
    logic [PIX_W-1:0] du;
    dl = abs_diff(c, l);
    du = abs_diff(c, u);
    return (dl > du) ? dl : du;
  endfunction

  logic edge_y;
  logic edge_u;
  logic edge_v;
  pcv_color_t grey;
  pcv_color_t marked;

  assign edge_y = max_diff(stage.pix.y, stage.left_yuv[23:16], up_yuv[23:16])
                  > edge_threshold;
  assign edge_u = max_diff(stage.pix.u, stage.left_yuv[15:8], up_yuv[15:8])
                  > edge_threshold;
  assign edge_v = max_diff(stage.pix.v, stage.left_yuv[7:0], up_yuv[7:0])
                  > edge_threshold;

  assign grey = '{red: stage.pix.y, green: stage.pix.y, blue: stage.pix.y};

  // Overlay: a luma edge paints red, a U edge adds green and a V edge adds
  // blue; a later mark clears the earlier grey only when nothing came before.
  always_comb begin
    marked = grey;
    if (stage.edge_ok) begin
      if (edge_y) begin
        marked = '{red: PIX_FULL, green: PIX_ZERO, blue: PIX_ZERO};
      end
      if (edge_u) begin
        marked.green = PIX_FULL;
        marked.blue  = PIX_ZERO;
        if (!edge_y) begin
          marked.red = PIX_ZERO;
        end
      end
      if (edge_v) begin
        marked.blue = PIX_FULL;
        if (!edge_y && !edge_u) begin
          marked.red   = PIX_ZERO;
          marked.green = PIX_ZERO;
        end
      end
    end
  end

  always_comb begin
    color = '{red: PIX_ZERO, green: PIX_ZERO, blue: PIX_ZERO};
    unique case (display_mode)
      MODE_RGB:   color = '{red: stage.pix.red, green: stage.pix.green,
                            blue: stage.pix.blue};
      MODE_Y:     color = grey;
      MODE_U:     color = '{red: stage.pix.u, green: stage.pix.u, blue: stage.pix.u};
      MODE_V:     color = '{red: stage.pix.v, green: stage.pix.v, blue: stage.pix.v};
      MODE_RED:   color.red = stage.pix.red;
      MODE_GREEN: color.green = stage.pix.green;
      MODE_BLUE:  color.blue = stage.pix.blue;
      MODE_HUE:   color = '{red: stage.pix.hue, green: stage.pix.hue,
                            blue: stage.pix.hue};
      MODE_SAT:   color = '{red: stage.pix.sat, green: stage.pix.sat,
                            blue: stage.pix.sat};
      MODE_VAL:   color = '{red: stage.pix.val, green: stage.pix.val,
                            blue: stage.pix.val};
      MODE_EDGE:  color = marked;
      default:    color = '{red: PIX_ZERO, green: PIX_ZERO, blue: PIX_ZERO};
    endcase
  end

endmodule

/* hdl/pixel_channel_view_edge_overlay.sv */
// Pixel channel viewer with a neighbor-difference edge overlay.
// Items enter on pixel_in in raster order, each carrying the Y, U, V, R, G,
// B, hue, saturation and value bytes of one pixel. For every input item exactly one item
// leaves on display_out: the display RGB chosen by display_mode, plus
// frame_end on the last pixel of the frame.
// Registers are written through cfg_write/cfg_index/cfg_data while the block
// is idle; the user must keep to this, the block does not enforce it. Index 0
// is display_mode, 1 image_width, 2 image_height and 3 edge_threshold.
// An accepted item is registered in the middle stage with its line-store read,
// shaded, and registered in the output register, which offers it on display_out.
// Throughput is one item per cycle while display_out is ready, set by the
// single-port-write line store that is read and written once per accepted item.
// Reset clears the raster counters, the left-neighbor register, both
// pipeline valids and loads the register defaults (640 by 480, threshold 10,
// full color). The line store is not cleared; row 0 reads it before it is
// written in the frame, and edge marks are masked on rows 0 and 1.
// When the receiver stalls, the output register holds, the middle stage
// keeps one more item, and only then does pixel_in drop ready.
module pixel_channel_view_edge_overlay
  import pcv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  pcv_pixel_if.sink            pixel_in,
  pcv_display_if.source        display_out,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

`include "assert_macros.svh"

  logic [MODE_W-1:0]   display_mode;
  logic [SIZE_W-1:0]   image_width;
  logic [SIZE_W-1:0]   image_height;
  logic [THRESH_W-1:0] edge_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode   <= MODE_RGB;
      image_width    <= WIDTH_RST;
      image_height   <= HEIGHT_RST;
      edge_threshold <= THRESH_RST;
    end else if (cfg_write) begin
      unique case (pcv_reg_t'(cfg_index))
        REG_DISPLAY_MODE:   display_mode   <= cfg_data[MODE_W-1:0];
        REG_IMAGE_WIDTH:    image_width    <= cfg_data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data[SIZE_W-1:0];
        REG_EDGE_THRESHOLD: edge_threshold <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the middle stage moves on whenever the output register is
  // empty or being emptied this cycle.
  logic       s1_valid;
  logic       out_valid;
  logic       s1_move;
  logic       accept;
  pcv_stage_t s1;

  assign s1_move         = !out_valid || display_out.ready;
  assign pixel_in.ready  = !s1_valid || s1_move;
  assign accept          = pixel_in.valid && pixel_in.ready;

  // Raster position. An image_width above the store depth is clamped to it,
  // and a zero width or height behaves as one.
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [YUV_W-1:0] left_pixel_yuv;
  logic [YUV_W-1:0] cur_yuv;
  logic             last_col;
  logic             last_row;
  pcv_pixel_t       pix;

  assign pix = '{y: pixel_in.pixel_y, u: pixel_in.pixel_u, v: pixel_in.pixel_v,
                 red: pixel_in.pixel_red, green: pixel_in.pixel_green,
                 blue: pixel_in.pixel_blue, hue: pixel_in.pixel_hue,
                 sat: pixel_in.pixel_saturation, val: pixel_in.pixel_value};
  assign cur_yuv = {pix.y, pix.u, pix.v};

  assign last_col = (32'(column_count) + 32'd1 >= 32'(image_width)) ||
                    (32'(column_count) + 32'd1 >= 32'(MAX_WIDTH));
  assign last_row = 32'(row_count) + 32'd1 >= 32'(image_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= '0;
      row_count      <= '0;
      left_pixel_yuv <= '0;
      s1_valid       <= 1'b0;
    end else begin
      if (accept) begin
        left_pixel_yuv <= cur_yuv;
        if (last_col) begin
          column_count <= '0;
          row_count    <= last_row ? '0 : row_count + 1'b1;
        end else begin
          column_count <= column_count + 1'b1;
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.pix       <= pix;
      s1.left_yuv  <= left_pixel_yuv;
      s1.edge_ok   <= (column_count != '0) && (row_count > ROW_W'(1));
      s1.frame_end <= last_col && last_row;
    end
  end

  // Previous row's YUV; the read is held with the middle stage.
  logic [YUV_W-1:0] up_yuv;

  pcv_ram #(
    .WIDTH (YUV_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (column_count),
    .wr_data (cur_yuv),
    .rd_en   (accept),
    .rd_addr (column_count),
    .rd_data (up_yuv)
  );

  pcv_color_t color;

  pcv_shade u_shade (
    .stage          (s1),
    .up_yuv         (up_yuv),
    .display_mode   (display_mode),
    .edge_threshold (edge_threshold),
    .color          (color)
  );

  // Output register.
  pcv_color_t out_color;
  logic       out_frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      out_color     <= color;
      out_frame_end <= s1.frame_end;
    end
  end

  assign display_out.valid     = out_valid;
  assign display_out.out_red   = out_color.red;
  assign display_out.out_green = out_color.green;
  assign display_out.out_blue  = out_color.blue;
  assign display_out.frame_end = out_frame_end;

  // A full, stalled pipeline must refuse new items.
  `PCV_ASSERT_IMP(a_full_stall_blocks, clk, rst,
                  s1_valid && out_valid && !display_out.ready, !pixel_in.ready)
  // A stalled middle stage keeps its item.
  `PCV_ASSERT_NXT(a_mid_holds, clk, rst,
                  s1_valid && !s1_move, s1_valid && $stable(s1))
  // The column wraps to zero after the last pixel of a row.
  `PCV_ASSERT_NXT(a_col_wraps, clk, rst, accept && last_col, column_count == '0)

endmodule
